// ===== sv/twalk_pkg.sv =====
// Shared types, constants and helpers of the Tremaux grid walker.
`timescale 1ns / 1ps
`default_nettype none
package twalk_pkg;

	localparam int MAX_SIDE    = 64;
	localparam int SIDE_BITS   = $clog2(MAX_SIDE);
	localparam int CFG_BITS    = 7;
	localparam int WEIGHT_BITS = 16;
	localparam int ADDR_BITS   = 2 * SIDE_BITS;
	localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
	localparam int NBR_COUNT   = 4;
	localparam int SLOT_BITS   = 3;
	localparam int DATA_BITS   = 32;
	localparam int PADDR_BITS  = 3;

	typedef logic [SIDE_BITS-1:0]   side_t;
	typedef logic [CFG_BITS-1:0]    dim_t;
	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [ADDR_BITS-1:0]   addr_t;
	typedef logic [SLOT_BITS-1:0]   slot_t;

	// Request codes.
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Read slots: the four neighbours in priority order, then the current cell.
	localparam slot_t SLOT_XM  = 3'd0;
	localparam slot_t SLOT_XP  = 3'd1;
	localparam slot_t SLOT_YM  = 3'd2;
	localparam slot_t SLOT_YP  = 3'd3;
	localparam slot_t SLOT_CUR = 3'd4;

	// Register indexes (paddr[2]).
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam dim_t RESET_SIDE = 7'd16;

	localparam weight_t DEAD_CODE = {WEIGHT_BITS{1'b1}};
	localparam weight_t SAT_CODE  = DEAD_CODE - 1'b1;

	typedef struct packed {
		logic  capture;
		logic  clr_step;
		logic  rd_en;
		slot_t rd_sel;
		logic  quick_apply;
		logic  step_apply;
		logic  start_apply;
	} twalk_cmd_t;

	typedef struct packed {
		logic quick;
		logic clr_last;
	} twalk_stat_t;

	// Zero acts as one, anything above the largest side acts as the largest side.
	function automatic dim_t eff_side(dim_t v);
		dim_t r;
		r = v;
		if (v == '0) r = dim_t'(1);
		else if (v > dim_t'(MAX_SIDE)) r = dim_t'(MAX_SIDE);
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/twalk_dp.sv =====
// Datapath of the walker: weight memory, position, neighbour slots and result register.
`timescale 1ns / 1ps
`default_nettype none
module twalk_dp (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire twalk_pkg::twalk_cmd_t   ctl,
	output twalk_pkg::twalk_stat_t       sts,
	input  wire twalk_pkg::dim_t         grid_width,
	input  wire twalk_pkg::dim_t         grid_height,
	input  wire logic [3:0]              open_mask,
	input  wire twalk_pkg::side_t        start_x,
	input  wire twalk_pkg::side_t        start_y,
	output twalk_pkg::side_t             new_x,
	output twalk_pkg::side_t             new_y,
	output logic                         arrived,
	output logic                         stuck
);

	twalk_pkg::weight_t mem [twalk_pkg::DEPTH];
	twalk_pkg::weight_t rdata_q;
	twalk_pkg::weight_t wgt_q [5];

	twalk_pkg::side_t   pos_x_q, pos_y_q, sx_q, sy_q;
	logic               halted_q;
	logic [3:0]         mask_q;
	twalk_pkg::addr_t   clr_cnt_q;
	logic               rd_vld_s1;
	twalk_pkg::slot_t   rd_sel_s1;

	twalk_pkg::dim_t    w_eff, h_eff, wm1, hm1, xe, ye;
	logic               on_grid, corner_cur;
	logic [3:0]         ok;
	twalk_pkg::side_t   nbr_x [4];
	twalk_pkg::side_t   nbr_y [4];
	twalk_pkg::addr_t   mem_addr;
	logic               mem_we;
	twalk_pkg::weight_t mem_wdata, new_w;
	logic [2:0]         sides, dead;
	logic               dead_mark, found;
	logic [1:0]         best;
	twalk_pkg::weight_t best_w;

	function automatic logic is_corner(twalk_pkg::side_t x, twalk_pkg::side_t y,
			twalk_pkg::dim_t wl, twalk_pkg::dim_t hl);
		return ({1'b0, x} == wl) && ({1'b0, y} == hl);
	endfunction

	assign w_eff      = twalk_pkg::eff_side(grid_width);
	assign h_eff      = twalk_pkg::eff_side(grid_height);
	assign wm1        = w_eff - 1'b1;
	assign hm1        = h_eff - 1'b1;
	assign xe         = {1'b0, pos_x_q};
	assign ye         = {1'b0, pos_y_q};
	assign on_grid    = (xe < w_eff) && (ye < h_eff);
	assign corner_cur = is_corner(pos_x_q, pos_y_q, wm1, hm1);

	assign nbr_x[0] = pos_x_q - 1'b1; assign nbr_y[0] = pos_y_q;
	assign nbr_x[1] = pos_x_q + 1'b1; assign nbr_y[1] = pos_y_q;
	assign nbr_x[2] = pos_x_q;        assign nbr_y[2] = pos_y_q - 1'b1;
	assign nbr_x[3] = pos_x_q;        assign nbr_y[3] = pos_y_q + 1'b1;

	// Sides leading off the grid are dropped.
	assign ok[0] = mask_q[0] && (pos_x_q != '0);
	assign ok[1] = mask_q[1] && ((xe + 7'd1) < w_eff);
	assign ok[2] = mask_q[2] && (pos_y_q != '0);
	assign ok[3] = mask_q[3] && ((ye + 7'd1) < h_eff);

	assign sts.quick    = halted_q || !on_grid || corner_cur;
	assign sts.clr_last = &clr_cnt_q;

	always_comb begin
		sides = '0;
		dead  = '0;
		for (int i = 0; i < twalk_pkg::NBR_COUNT; i++) begin
			if (ok[i]) begin
				sides = sides + 3'd1;
				if (wgt_q[i] == twalk_pkg::DEAD_CODE) dead = dead + 3'd1;
			end
		end
		dead_mark = (sides == 3'd1) || ((sides >= 3'd2) && (dead >= sides - 3'd1));
		if (dead_mark) new_w = twalk_pkg::DEAD_CODE;
		else if (wgt_q[twalk_pkg::SLOT_CUR] >= twalk_pkg::SAT_CODE) new_w = twalk_pkg::SAT_CODE;
		else new_w = wgt_q[twalk_pkg::SLOT_CUR] + 1'b1;
	end

	// First eligible neighbour with the least weight.
	always_comb begin
		found  = 1'b0;
		best   = '0;
		best_w = '0;
		for (int i = 0; i < twalk_pkg::NBR_COUNT; i++) begin
			if (ok[i] && (wgt_q[i] < twalk_pkg::SAT_CODE) && (!found || (wgt_q[i] < best_w))) begin
				found  = 1'b1;
				best   = 2'(i);
				best_w = wgt_q[i];
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = new_w;
		case (ctl.rd_sel)
			twalk_pkg::SLOT_XM: mem_addr = {nbr_x[0], nbr_y[0]};
			twalk_pkg::SLOT_XP: mem_addr = {nbr_x[1], nbr_y[1]};
			twalk_pkg::SLOT_YM: mem_addr = {nbr_x[2], nbr_y[2]};
			twalk_pkg::SLOT_YP: mem_addr = {nbr_x[3], nbr_y[3]};
			default:            mem_addr = {pos_x_q, pos_y_q};
		endcase
		if (ctl.clr_step) begin
			mem_we    = 1'b1;
			mem_wdata = '0;
			mem_addr  = clr_cnt_q;
		end else if (ctl.step_apply) begin
			mem_we   = (sides != 3'd0);
			mem_addr = {pos_x_q, pos_y_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (ctl.rd_en) rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			halted_q  <= 1'b0;
			clr_cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_sel_s1 <= '0;
		end else begin
			rd_vld_s1 <= ctl.rd_en;
			rd_sel_s1 <= ctl.rd_sel;
			if (ctl.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (ctl.start_apply) begin
				pos_x_q  <= sx_q;
				pos_y_q  <= sy_q;
				halted_q <= 1'b0;
			end
			if (ctl.quick_apply && !halted_q && on_grid && corner_cur) halted_q <= 1'b1;
			if (ctl.step_apply && found) begin
				pos_x_q <= nbr_x[best];
				pos_y_q <= nbr_y[best];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			mask_q <= open_mask;
			sx_q   <= start_x;
			sy_q   <= start_y;
		end
		for (int i = 0; i < 5; i++) begin
			if (rd_vld_s1 && (rd_sel_s1 == twalk_pkg::SLOT_BITS'(i))) wgt_q[i] <= rdata_q;
		end
		if (ctl.start_apply) begin
			new_x   <= sx_q;
			new_y   <= sy_q;
			arrived <= is_corner(sx_q, sy_q, wm1, hm1);
			stuck   <= 1'b0;
		end else if (ctl.quick_apply) begin
			new_x   <= pos_x_q;
			new_y   <= pos_y_q;
			arrived <= halted_q || (on_grid && corner_cur);
			stuck   <= 1'b0;
		end else if (ctl.step_apply) begin
			if (found) begin
				new_x   <= nbr_x[best];
				new_y   <= nbr_y[best];
				arrived <= is_corner(nbr_x[best], nbr_y[best], wm1, hm1);
				stuck   <= 1'b0;
			end else begin
				new_x   <= pos_x_q;
				new_y   <= pos_y_q;
				arrived <= 1'b0;
				stuck   <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/twalk_ctrl.sv =====
// Controller state machine of the walker: sequences clearing, reads and write-back.
`timescale 1ns / 1ps
`default_nettype none
module twalk_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire logic                  cmd,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	input  wire twalk_pkg::twalk_stat_t sts,
	output twalk_pkg::twalk_cmd_t      ctl
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_READ,
		S_WAIT,
		S_APPLY,
		S_START
	} state_t;

	state_t           state_q;
	twalk_pkg::slot_t slot_q;
	logic             start_pend_q;
	logic             rsp_valid_q;
	logic             out_free, emit;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign emit      = ctl.quick_apply || ctl.step_apply || ctl.start_apply;

	always_comb begin
		ctl = '0;
		ctl.rd_sel = slot_q;
		case (state_q)
			S_CLEAR: ctl.clr_step    = 1'b1;
			S_IDLE:  ctl.capture     = req_valid;
			S_CHECK: ctl.quick_apply = sts.quick && out_free;
			S_READ:  ctl.rd_en       = 1'b1;
			S_APPLY: ctl.step_apply  = out_free;
			S_START: ctl.start_apply = out_free;
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			slot_q       <= twalk_pkg::SLOT_XM;
			start_pend_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rsp_valid_q <= emit || (rsp_valid_q && rsp_stall);
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q      <= start_pend_q ? S_START : S_IDLE;
						start_pend_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						if (cmd == twalk_pkg::CMD_START) begin
							state_q      <= S_CLEAR;
							start_pend_q <= 1'b1;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (!sts.quick) begin
						state_q <= S_READ;
						slot_q  <= twalk_pkg::SLOT_XM;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (slot_q == twalk_pkg::SLOT_CUR) state_q <= S_WAIT;
					else slot_q <= slot_q + 3'd1;
				end
				S_WAIT:  state_q <= S_APPLY;
				S_APPLY: if (out_free) state_q <= S_IDLE;
				S_START: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/tremaux_grid_walker.sv =====
// Top level of the Tremaux grid walker: configuration registers and block wiring.
//
//  channel    signals                                   direction  accepted when
//  request    req_valid, req_stall, cmd, open_mask,     in         req_valid && !req_stall
//             start_x, start_y
//  response   rsp_valid, rsp_stall, new_x, new_y,       out        rsp_valid && !rsp_stall
//             arrived, stuck
//  config     psel, penable, pwrite, paddr, pwdata,     in         psel && penable && pwrite
//             prdata, pready
//
// A step request runs through a check state, five reads of the single-port weight memory
// (four neighbours, then the current cell), a wait state for the last read to land and a
// write-back state that also loads the response; the controller then returns to idle.
// A step that halts, finds the walker off the grid or already halted loads its response in
// the check state, skips the reads and returns to idle.
// A start request and reset both run a clearing pass over the 4096-entry weight memory, one
// entry a cycle; a start request then loads its response in the start state, and after reset
// the block takes no request until the pass is done. Configuration writes are taken at any time.
// The response sits in an output register; a stall on it holds the result and delays only
// the final cycle of the following request, which waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none
module tremaux_grid_walker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  req_valid,
	output logic                                       req_stall,
	input  wire logic                                  cmd,
	input  wire logic [3:0]                            open_mask,
	input  wire twalk_pkg::side_t                      start_x,
	input  wire twalk_pkg::side_t                      start_y,
	output logic                                       rsp_valid,
	input  wire logic                                  rsp_stall,
	output twalk_pkg::side_t                           new_x,
	output twalk_pkg::side_t                           new_y,
	output logic                                       arrived,
	output logic                                       stuck,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [twalk_pkg::PADDR_BITS-1:0]      paddr,
	input  wire logic [twalk_pkg::DATA_BITS-1:0]       pwdata,
	output logic [twalk_pkg::DATA_BITS-1:0]            prdata,
	output logic                                       pready
);

	twalk_pkg::dim_t        grid_width_q, grid_height_q;
	twalk_pkg::twalk_cmd_t  ctl;
	twalk_pkg::twalk_stat_t sts;
	logic                   cfg_wr;

	// Register file: always ready, written in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= twalk_pkg::RESET_SIDE;
			grid_height_q <= twalk_pkg::RESET_SIDE;
		end else if (cfg_wr) begin
			case (paddr[2])
				twalk_pkg::REG_WIDTH:  grid_width_q  <= pwdata[twalk_pkg::CFG_BITS-1:0];
				twalk_pkg::REG_HEIGHT: grid_height_q <= pwdata[twalk_pkg::CFG_BITS-1:0];
				default:               grid_width_q  <= grid_width_q;
			endcase
		end
	end

	// Read back the raw register value, not the clamped one.
	always_comb begin
		case (paddr[2])
			twalk_pkg::REG_WIDTH:
				prdata = {{(twalk_pkg::DATA_BITS-twalk_pkg::CFG_BITS){1'b0}}, grid_width_q};
			default:
				prdata = {{(twalk_pkg::DATA_BITS-twalk_pkg::CFG_BITS){1'b0}}, grid_height_q};
		endcase
	end

	// Sequencer: one request at a time.
	twalk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Weight memory, walker position and the response register.
	twalk_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.open_mask   (open_mask),
		.start_x     (start_x),
		.start_y     (start_y),
		.new_x       (new_x),
		.new_y       (new_y),
		.arrived     (arrived),
		.stuck       (stuck)
	);

endmodule
`default_nettype wire

// ===== sv/twalk_checker.sv =====
// Port-level checks of the walker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module twalk_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_stall,
	input wire logic             rsp_valid,
	input wire logic             rsp_stall,
	input wire twalk_pkg::side_t new_x,
	input wire twalk_pkg::side_t new_y,
	input wire logic             arrived,
	input wire logic             stuck
);

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(new_x) && $stable(new_y)
			&& $stable(arrived) && $stable(stuck))
		else $error("response changed while stalled");

	// One request in flight: the port closes right after an acceptance.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another was in flight");

	// No response can be produced in the cycle of acceptance.
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(rsp_valid))
		else $error("response appeared without any work cycle");

	// A stuck walker never reports arrival.
	a_stuck_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(stuck && arrived))
		else $error("stuck and arrived both set");

	// Reset leaves no response pending and the request port closed.
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !rsp_valid && req_stall)
		else $error("response or open request port straight after reset");

endmodule

bind tremaux_grid_walker twalk_checker u_twalk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.new_x     (new_x),
	.new_y     (new_y),
	.arrived   (arrived),
	.stuck     (stuck)
);
`default_nettype wire
